/* rtl/lcwc_pkg.sv */
package lcwc_pkg;

	localparam int unsigned FILTER_COUNT_DEF = 2;

	localparam int unsigned CODE_W    = 24;
	localparam int unsigned SAMPLE_W  = 25;
	localparam int unsigned DIVISOR_W = 16;
	localparam int unsigned TOTAL_W   = 24;
	localparam int unsigned NET_W     = 25;
	localparam int unsigned LIMIT_W   = 24;
	localparam int unsigned ADDR_W    = 4;
	localparam int unsigned DATA_W    = 32;

	localparam logic [CODE_W-1:0]    SIGN_FLIP     = 24'h800000;
	localparam logic [DIVISOR_W-1:0] SCALE_RESET   = 16'd430;
	localparam logic [LIMIT_W-1:0]   ALARM_RESET   = 24'd4900;
	localparam logic [DIVISOR_W-1:0] DIVISOR_ONE   = 16'd1;

	typedef enum logic [1:0] {
		REG_ZERO_OFFSET   = 2'd0,
		REG_TARE_COUNTS   = 2'd1,
		REG_SCALE_DIVISOR = 2'd2,
		REG_ALARM_LIMIT   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] zero_offset;
		logic signed [SAMPLE_W-1:0] tare_counts;
		logic [DIVISOR_W-1:0]       scale_divisor;
		logic [LIMIT_W-1:0]         alarm_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_TOT,
		ST_NET,
		ST_WB
	} state_t;

endpackage

/* rtl/lcwc_regs.sv */
module lcwc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lcwc_pkg::ADDR_W-1:0]   paddr,
	input  logic [lcwc_pkg::DATA_W-1:0]   pwdata,
	output logic [lcwc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output lcwc_pkg::cfg_t                cfg
);

	logic                 wr_en;
	lcwc_pkg::reg_idx_t   idx;
	lcwc_pkg::cfg_t       cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = lcwc_pkg::reg_idx_t'(paddr[lcwc_pkg::ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_offset   <= '0;
			cfg_q.tare_counts   <= '0;
			cfg_q.scale_divisor <= lcwc_pkg::SCALE_RESET;
			cfg_q.alarm_limit   <= lcwc_pkg::ALARM_RESET;
		end else if (wr_en) begin
			case (idx)
				lcwc_pkg::REG_ZERO_OFFSET: begin
					cfg_q.zero_offset <= pwdata[lcwc_pkg::SAMPLE_W-1:0];
				end
				lcwc_pkg::REG_TARE_COUNTS: begin
					cfg_q.tare_counts <= pwdata[lcwc_pkg::SAMPLE_W-1:0];
				end
				lcwc_pkg::REG_SCALE_DIVISOR: begin
					cfg_q.scale_divisor <= pwdata[lcwc_pkg::DIVISOR_W-1:0];
				end
				lcwc_pkg::REG_ALARM_LIMIT: begin
					cfg_q.alarm_limit <= pwdata[lcwc_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// signed registers read back sign-extended
	always_comb begin
		case (idx)
			lcwc_pkg::REG_ZERO_OFFSET:
				prdata = lcwc_pkg::DATA_W'(cfg_q.zero_offset);
			lcwc_pkg::REG_TARE_COUNTS:
				prdata = lcwc_pkg::DATA_W'(cfg_q.tare_counts);
			lcwc_pkg::REG_SCALE_DIVISOR:
				prdata = lcwc_pkg::DATA_W'(cfg_q.scale_divisor);
			lcwc_pkg::REG_ALARM_LIMIT:
				prdata = lcwc_pkg::DATA_W'(cfg_q.alarm_limit);
			default:
				prdata = '0;
		endcase
	end

endmodule

/* rtl/lcwc_div.sv */
module lcwc_div #(
	parameter int unsigned DW = 26
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [DW-1:0]                    dividend,
	input  logic [lcwc_pkg::DIVISOR_W-1:0]   divisor,
	output logic                             done,
	output logic [DW-1:0]                    quotient
);

	localparam int unsigned CW = $clog2(DW + 1);
	localparam int unsigned VW = lcwc_pkg::DIVISOR_W;

	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [VW:0]   shifted;
	logic [VW:0]   trial;
	logic          ge;
	logic [VW-1:0] rem_nxt;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	assign shifted = {rem_q, quo_q[DW-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign rem_nxt = ge ? trial[VW-1:0] : shifted[VW-1:0];

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

endmodule

/* rtl/load_cell_weight_conditioner.sv */
// Load-cell weight conditioner. Each raw_code beat is a 24-bit two's-complement
// converter word; its sign bit is flipped to offset binary and zero_offset is
// subtracted. A negative sample is replaced by the previous sample of the batch
// (0 at batch start). Every FILTER_COUNT samples the batch sum is averaged with
// truncation and one result beat is produced: total_grams = average /
// scale_divisor (saturated to 24 bits), net_grams = max(0, average -
// tare_counts) / scale_divisor (saturated to 25 bits), and overload when the
// unsaturated total exceeds alarm_limit. A scale_divisor of 0 acts as 1.
// Samples inside a batch are taken one per cycle. The last sample of a batch
// starts three divisions on a single radix-2 restoring divider that retires
// one quotient bit per cycle, DW = max(26, 25 + clog2(FILTER_COUNT)); the
// next sample is taken only after all three divisions are done and the
// result register has been loaded, which waits on out_ready while the
// previous result is still held. The result register lets the
// next batch run while a finished result still waits on out_ready. Registers
// sit on an APB port at byte address 4 * index; write them only while idle.
module load_cell_weight_conditioner #(
	parameter int unsigned FILTER_COUNT = lcwc_pkg::FILTER_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lcwc_pkg::ADDR_W-1:0]     paddr,
	input  logic [lcwc_pkg::DATA_W-1:0]     pwdata,
	output logic [lcwc_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lcwc_pkg::CODE_W-1:0]     raw_code,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lcwc_pkg::TOTAL_W-1:0]    total_grams,
	output logic [lcwc_pkg::NET_W-1:0]      net_grams,
	output logic                            overload
);

	localparam int unsigned SW    = lcwc_pkg::SAMPLE_W;
	localparam int unsigned SUM_W = SW + $clog2(FILTER_COUNT);
	localparam int unsigned DW    = (SUM_W > SW + 1) ? SUM_W : SW + 1;
	localparam int unsigned CNT_W = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
	localparam int unsigned VW    = lcwc_pkg::DIVISOR_W;

	lcwc_pkg::cfg_t   cfg;
	lcwc_pkg::state_t state_q;
	lcwc_pkg::state_t state_nxt;

	// batch accumulation
	logic [SUM_W-1:0]                sum_q;
	logic [SW-1:0]                   prev_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [lcwc_pkg::CODE_W-1:0]     code;
	logic signed [SW:0]              offs_sample;
	logic [SW-1:0]                   sample;
	logic [SUM_W-1:0]                sum_new;
	logic                            in_beat;
	logic                            last;

	// divider hookup and intermediate results
	logic                            div_start;
	logic [DW-1:0]                   div_dividend;
	logic [VW-1:0]                   div_divisor;
	logic                            div_done;
	logic [DW-1:0]                   div_quot;
	logic [VW-1:0]                   scale_eff;
	logic [SW-1:0]                   avg_q;
	logic [SW-1:0]                   total_q;
	logic signed [SW+1:0]            diff;

	// result register
	logic                            out_load;
	logic                            out_valid_q;
	logic [lcwc_pkg::TOTAL_W-1:0]    total_grams_q;
	logic [lcwc_pkg::NET_W-1:0]      net_grams_q;
	logic                            overload_q;

	lcwc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lcwc_div #(
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Flip to offset binary, remove the zero offset, and fall back to the
	// previous sample when the result goes negative.
	assign code        = raw_code ^ lcwc_pkg::SIGN_FLIP;
	assign offs_sample = $signed({2'b00, code}) - $signed({cfg.zero_offset[SW-1], cfg.zero_offset});
	assign sample      = offs_sample[SW] ? prev_q : offs_sample[SW-1:0];
	assign sum_new     = sum_q + SUM_W'(sample);
	assign in_beat     = in_valid && in_ready;
	assign last        = (cnt_q == CNT_W'(FILTER_COUNT - 1));

	assign scale_eff = (cfg.scale_divisor == '0) ? lcwc_pkg::DIVISOR_ONE : cfg.scale_divisor;
	// average minus tare; positive values stay below 2^26
	assign diff      = $signed({2'b00, avg_q}) - $signed({{2{cfg.tare_counts[SW-1]}}, cfg.tare_counts});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcwc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lcwc_pkg::ST_IDLE: begin
				if (in_beat && last) state_nxt = lcwc_pkg::ST_AVG;
			end
			lcwc_pkg::ST_AVG: begin
				if (div_done) state_nxt = lcwc_pkg::ST_TOT;
			end
			lcwc_pkg::ST_TOT: begin
				if (div_done) state_nxt = lcwc_pkg::ST_NET;
			end
			lcwc_pkg::ST_NET: begin
				if (div_done) state_nxt = lcwc_pkg::ST_WB;
			end
			lcwc_pkg::ST_WB: begin
				if (!out_valid_q || out_ready) state_nxt = lcwc_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = lcwc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = VW'(FILTER_COUNT);
		out_load     = 1'b0;
		case (state_q)
			lcwc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				// last sample of the batch: average by the filter length
				if (in_valid && last) begin
					div_start    = 1'b1;
					div_dividend = DW'(sum_new);
				end
			end
			lcwc_pkg::ST_AVG: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = DW'(div_quot[SW-1:0]);
					div_divisor  = scale_eff;
				end
			end
			lcwc_pkg::ST_TOT: begin
				// negative net divides zero, which clamps it
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = diff[SW+1] ? '0 : DW'(diff[SW:0]);
					div_divisor  = scale_eff;
				end
			end
			lcwc_pkg::ST_NET: begin
			end
			lcwc_pkg::ST_WB: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	// Accumulate the batch; clear everything on its last sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
			cnt_q  <= '0;
		end else if (in_beat) begin
			if (last) begin
				sum_q  <= '0;
				prev_q <= '0;
				cnt_q  <= '0;
			end else begin
				sum_q  <= sum_new;
				prev_q <= sample;
				cnt_q  <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Hold the average and the unsaturated total between divisions.
	always_ff @(posedge clk) begin
		if (state_q == lcwc_pkg::ST_AVG && div_done) begin
			avg_q <= div_quot[SW-1:0];
		end
		if (state_q == lcwc_pkg::ST_TOT && div_done) begin
			total_q <= div_quot[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Saturate into the result register; net quotient still sits in the divider.
	always_ff @(posedge clk) begin
		if (out_load) begin
			total_grams_q <= (total_q > SW'({lcwc_pkg::TOTAL_W{1'b1}})) ?
				'1 : total_q[lcwc_pkg::TOTAL_W-1:0];
			net_grams_q   <= (div_quot > DW'({lcwc_pkg::NET_W{1'b1}})) ?
				'1 : div_quot[lcwc_pkg::NET_W-1:0];
			overload_q    <= total_q > SW'(cfg.alarm_limit);
		end
	end

	assign out_valid   = out_valid_q;
	assign total_grams = total_grams_q;
	assign net_grams   = net_grams_q;
	assign overload    = overload_q;

endmodule

/* tb/load_cell_weight_conditioner_tb.sv */
`timescale 1ns / 100ps

typedef struct packed {
	logic [lcwc_pkg::TOTAL_W-1:0] total;
	logic [lcwc_pkg::NET_W-1:0]   net;
	logic                         overload;
} weighing_t;

// Tracks the batch filter and holds the weighings still owed by the block.
class weighing_scoreboard;
	logic signed [lcwc_pkg::SAMPLE_W-1:0] zero_offset;
	logic signed [lcwc_pkg::SAMPLE_W-1:0] tare_counts;
	logic [lcwc_pkg::DIVISOR_W-1:0]       scale_divisor;
	logic [lcwc_pkg::LIMIT_W-1:0]         alarm_limit;
	longint                               batch_sum;
	longint                               last_sample;
	int unsigned                          batch_fill;
	weighing_t                            owed[$];
	int                                   mismatches;

	function new();
		zero_offset   = '0;
		tare_counts   = '0;
		scale_divisor = lcwc_pkg::SCALE_RESET;
		alarm_limit   = lcwc_pkg::ALARM_RESET;
		batch_sum     = 0;
		last_sample   = 0;
		batch_fill    = 0;
		mismatches    = 0;
	endfunction

	function void write_register(lcwc_pkg::reg_idx_t idx,
	                             logic [lcwc_pkg::DATA_W-1:0] value);
		case (idx)
			lcwc_pkg::REG_ZERO_OFFSET:   zero_offset   = value[lcwc_pkg::SAMPLE_W-1:0];
			lcwc_pkg::REG_TARE_COUNTS:   tare_counts   = value[lcwc_pkg::SAMPLE_W-1:0];
			lcwc_pkg::REG_SCALE_DIVISOR: scale_divisor = value[lcwc_pkg::DIVISOR_W-1:0];
			lcwc_pkg::REG_ALARM_LIMIT:   alarm_limit   = value[lcwc_pkg::LIMIT_W-1:0];
			default: ;
		endcase
	endfunction

	function void take_sample(logic [lcwc_pkg::CODE_W-1:0] code);
		longint    sample;
		longint    average;
		longint    divisor;
		longint    grams;
		longint    net_counts;
		longint    net;
		weighing_t w;

		sample = longint'(code ^ lcwc_pkg::SIGN_FLIP) - longint'(zero_offset);
		if (sample < 0)
			sample = last_sample;
		batch_sum   += sample;
		last_sample  = sample;
		batch_fill++;
		if (batch_fill < lcwc_pkg::FILTER_COUNT_DEF)
			return;

		average    = batch_sum / longint'(lcwc_pkg::FILTER_COUNT_DEF);
		divisor    = (scale_divisor == '0) ? 1 : longint'(scale_divisor);
		grams      = average / divisor;
		net_counts = average - longint'(tare_counts);
		net        = (net_counts < 0) ? 0 : net_counts / divisor;

		w.total    = (grams > longint'(24'hFF_FFFF)) ? '1 : grams[lcwc_pkg::TOTAL_W-1:0];
		w.net      = (net > longint'(25'h1FF_FFFF)) ? '1 : net[lcwc_pkg::NET_W-1:0];
		w.overload = (grams > longint'(alarm_limit));
		owed.push_back(w);

		batch_sum   = 0;
		last_sample = 0;
		batch_fill  = 0;
	endfunction

	function void report_mismatch(string what, longint got, longint want);
		$display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endfunction

	function void check_weighing(logic [lcwc_pkg::TOTAL_W-1:0] total,
	                             logic [lcwc_pkg::NET_W-1:0] net,
	                             logic overload);
		weighing_t w;

		if (owed.size() == 0) begin
			report_mismatch("unexpected weighing beat, total_grams", total, -1);
			return;
		end
		w = owed.pop_front();
		if (total !== w.total)
			report_mismatch("total_grams", total, w.total);
		if (net !== w.net)
			report_mismatch("net_grams", net, w.net);
		if (overload !== w.overload)
			report_mismatch("overload", overload, w.overload);
	endfunction
endclass

module load_cell_weight_conditioner_tb;

	// A batch closes with three serial divisions; allow margin.
	localparam int SETTLE_CYCLES = 120;
	localparam int RANDOM_ITEMS  = 700;
	localparam int CALM_ITEMS    = 100;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [lcwc_pkg::ADDR_W-1:0]   paddr;
	logic [lcwc_pkg::DATA_W-1:0]   pwdata;
	logic [lcwc_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_ready;
	logic [lcwc_pkg::CODE_W-1:0]   raw_code;
	logic                          out_valid;
	logic                          out_ready;
	logic [lcwc_pkg::TOTAL_W-1:0]  total_grams;
	logic [lcwc_pkg::NET_W-1:0]    net_grams;
	logic                          overload;

	weighing_scoreboard sb = new();

	// Random idle bursts on both sides while set; clear for the calm tail.
	bit throttle;
	int stall_left;

	load_cell_weight_conditioner #(
		.FILTER_COUNT(lcwc_pkg::FILTER_COUNT_DEF)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_code   (raw_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.total_grams(total_grams),
		.net_grams  (net_grams),
		.overload   (overload)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Monitor both channels at the edge. Retire the result beat first, then
	// note the sample beat; a sample never feeds a result on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_weighing(total_grams, net_grams, overload);
			if (in_valid && in_ready)
				sb.take_sample(raw_code);
		end
	end

	// Receiver: accept by default, drop ready for random bursts while throttled.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (throttle && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 12);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Present one code and hold it until the beat is taken. Valid stays high
	// on return, so the caller must either send again or call settle().
	task automatic send_code(input logic [lcwc_pkg::CODE_W-1:0] code);
		int gap;

		if (throttle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_code <= code;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid, wait for every owed weighing, then wait out a margin before
	// touching registers; a half-filled batch stays open. The first edge
	// lets the monitor note the last sample beat before the queue is read.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup phase, access phase, then an idle phase with psel low.
	task automatic write_reg(input lcwc_pkg::reg_idx_t idx,
	                         input logic [lcwc_pkg::DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_register(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Pick a register value, leaning on the extremes of each range.
	function automatic logic [lcwc_pkg::DATA_W-1:0] pick_value(lcwc_pkg::reg_idx_t idx);
		logic [lcwc_pkg::DATA_W-1:0] v;

		v = $urandom();
		case (idx)
			lcwc_pkg::REG_ZERO_OFFSET, lcwc_pkg::REG_TARE_COUNTS: begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = 32'h0100_0000;
					2: v = 32'h00FF_FFFF;
					3: v = $urandom_range(0, 24'hFF_FFFF);
					default: ;
				endcase
			end
			lcwc_pkg::REG_SCALE_DIVISOR: begin
				case ($urandom_range(0, 6))
					0: v = '0;
					1: v = 32'd1;
					2: v = 32'h0000_FFFF;
					3, 4, 5: v = $urandom_range(1, 1000);
					default: ;
				endcase
			end
			lcwc_pkg::REG_ALARM_LIMIT: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = 32'h00FF_FFFF;
					2, 3: v = $urandom_range(0, 40000);
					default: ;
				endcase
			end
			default: ;
		endcase
		return v;
	endfunction

	// Uniform codes part of the time, the rest pinned at the sign boundary and near zero.
	function automatic logic [lcwc_pkg::CODE_W-1:0] pick_code();
		logic [lcwc_pkg::CODE_W-1:0] c;

		c = lcwc_pkg::CODE_W'($urandom());
		case ($urandom_range(0, 9))
			0: c = 24'h7F_FFFF;
			1: c = 24'h80_0000;
			2: c = 24'h00_0000;
			3: c = 24'hFF_FFFF;
			4: c = lcwc_pkg::CODE_W'($urandom_range(0, 4095));
			5: c = -lcwc_pkg::CODE_W'($urandom_range(1, 4096));
			default: ;
		endcase
		return c;
	endfunction

	initial begin
		int sent;
		int run;

		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		raw_code   = '0;
		out_ready  = 1'b0;
		throttle   = 1'b0;
		stall_left = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: code extremes on both sides of the sign flip.
		send_code(24'h00_0000);
		send_code(24'h7F_FFFF);
		send_code(24'h80_0000);
		send_code(24'hFF_FFFF);
		settle();

		// Largest samples with divisor 1: total saturates, net saturates,
		// overload still compares the unsaturated total.
		write_reg(lcwc_pkg::REG_ZERO_OFFSET, 32'h0100_0000);
		write_reg(lcwc_pkg::REG_TARE_COUNTS, 32'h0100_0000);
		write_reg(lcwc_pkg::REG_SCALE_DIVISOR, 32'd1);
		write_reg(lcwc_pkg::REG_ALARM_LIMIT, 32'h00FF_FFFF);
		send_code(24'h7F_FFFF);
		send_code(24'h7F_FFFF);
		settle();

		// Zero divisor acts as one.
		write_reg(lcwc_pkg::REG_SCALE_DIVISOR, 32'd0);
		send_code(24'h7F_FFFF);
		send_code(24'h80_0000);
		settle();

		// Large offset: negative samples fall back to the previous one, which
		// is zero at batch start. Large tare drives net negative, so it clamps.
		write_reg(lcwc_pkg::REG_ZERO_OFFSET, 32'h00FF_FFFF);
		write_reg(lcwc_pkg::REG_TARE_COUNTS, 32'h00FF_FFFF);
		write_reg(lcwc_pkg::REG_SCALE_DIVISOR, 32'h0000_FFFF);
		write_reg(lcwc_pkg::REG_ALARM_LIMIT, 32'd0);
		send_code(24'h00_0000);
		send_code(24'h7F_FFFF);
		settle();
		write_reg(lcwc_pkg::REG_ZERO_OFFSET, 32'h0080_0000);
		write_reg(lcwc_pkg::REG_SCALE_DIVISOR, 32'd1);
		send_code(24'h7F_FFFF);
		send_code(24'h00_0000);
		send_code(24'h7F_FFFF);
		send_code(24'h80_0000);
		settle();

		// Register write halfway through a batch applies to the rest of it.
		send_code(24'h12_3456);
		settle();
		write_reg(lcwc_pkg::REG_ZERO_OFFSET, 32'd0);
		write_reg(lcwc_pkg::REG_TARE_COUNTS, 32'd1000);
		write_reg(lcwc_pkg::REG_SCALE_DIVISOR, 32'd7);
		send_code(24'h65_4321);
		settle();

		// Random phases, each under a fresh setting. Phase lengths are uneven,
		// so batches straddle register writes too. The last stretch runs with
		// no idling on either side.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			for (int r = 0; r < 4; r++)
				write_reg(lcwc_pkg::reg_idx_t'(r), pick_value(lcwc_pkg::reg_idx_t'(r)));
			if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
				throttle = 1'b0;
				run      = RANDOM_ITEMS - sent;
			end else begin
				throttle = ($urandom_range(0, 3) != 0);
				run      = $urandom_range(40, 120);
				if (run > RANDOM_ITEMS - CALM_ITEMS - sent)
					run = RANDOM_ITEMS - CALM_ITEMS - sent;
			end
			repeat (run) send_code(pick_code());
			sent += run;
			settle();
		end

		if (sb.owed.size() == 0 && sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/lcwc_pkg.sv
rtl/lcwc_regs.sv
rtl/lcwc_div.sv
rtl/load_cell_weight_conditioner.sv
tb/load_cell_weight_conditioner_tb.sv
